// ===== src/nearest_palette_color_top_macros.svh =====
// Assertion macros shared by the block's checks.
// Every macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef NEAREST_PALETTE_COLOR_TOP_MACROS_SVH
`define NEAREST_PALETTE_COLOR_TOP_MACROS_SVH

// The consequence must hold in the same cycle as the antecedent
`define NPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest palette colour check failed");

// The consequence must hold in the cycle after the antecedent
`define NPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest palette colour check failed");

`endif

// ===== src/npc_pkg.sv =====
package npc_pkg;

    // Fixed field widths of the result
    localparam int INDEX_W = 8;
    localparam int DIST_W  = 14;

    // Largest distance the result field can carry
    localparam logic [DIST_W-1:0] DIST_FIELD_MAX = 14'd16383;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } npc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic write_en;    // store the incoming palette entry
        logic load_query;  // latch the query colour, restart the address counter
        logic issue;       // read the next palette entry into the pipeline
        logic finish;      // move the best match into the output register
    } npc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_addr;   // the address counter points at the final entry
        logic pipe_busy;   // entries still travelling through the distance pipeline
        logic out_busy;    // output register holds a result not yet taken
    } npc_status_t;

endpackage

// ===== src/npc_ctrl.sv =====
module npc_ctrl
    import npc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        operation,
    input  npc_status_t status,
    output logic        in_ready,
    output npc_cmd_t    cmd
);

    npc_state_t state_reg;
    npc_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.write_en   = 1'b0;
        cmd.load_query = 1'b0;
        cmd.issue      = 1'b0;
        cmd.finish     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (operation == OP_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.write_en = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last distance to settle and for a free output slot
                if (!status.pipe_busy && !status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/npc_datapath.sv =====
module npc_datapath
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int COMPONENT_BITS  = 6
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  npc_cmd_t                  cmd,
    input  logic [INDEX_W-1:0]        entry_index,
    input  logic [COMPONENT_BITS-1:0] red,
    input  logic [COMPONENT_BITS-1:0] green,
    input  logic [COMPONENT_BITS-1:0] blue,
    input  logic                      out_ready,
    output npc_status_t               status,
    output logic                      out_valid,
    output logic [INDEX_W-1:0]        nearest_index,
    output logic [DIST_W-1:0]         nearest_distance
);

    localparam int CB     = COMPONENT_BITS;
    localparam int AW     = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int EW     = 3 * CB;
    localparam int SQW    = 2 * CB;
    localparam int DW     = 2 * CB + 2;
    localparam int SAT_W  = (DW > DIST_W) ? DW : DIST_W;
    localparam int RANGEW = 11;

    // Palette memory
    logic [EW-1:0] palette_mem [PALETTE_ENTRIES];

    // Query colour
    logic [CB-1:0] q_red_reg;
    logic [CB-1:0] q_green_reg;
    logic [CB-1:0] q_blue_reg;

    // Scan address
    logic [AW-1:0] addr_reg;

    // Read stage
    logic          s1_valid_reg;
    logic [AW-1:0] s1_idx_reg;
    logic [EW-1:0] s1_data_reg;

    // Square stage
    logic           s2_valid_reg;
    logic [AW-1:0]  s2_idx_reg;
    logic [SQW-1:0] s2_sq_r_reg;
    logic [SQW-1:0] s2_sq_g_reg;
    logic [SQW-1:0] s2_sq_b_reg;

    // Sum stage
    logic          s3_valid_reg;
    logic [AW-1:0] s3_idx_reg;
    logic [DW-1:0] s3_sum_reg;

    // Running best
    logic [AW-1:0] best_idx_reg;
    logic [DW-1:0] best_dist_reg;

    // Output register
    logic               out_valid_reg;
    logic [INDEX_W-1:0] nearest_index_reg;
    logic [DIST_W-1:0]  nearest_distance_reg;

    logic          wr_in_range;
    logic [CB-1:0] ent_r;
    logic [CB-1:0] ent_g;
    logic [CB-1:0] ent_b;
    logic [CB-1:0] diff_r;
    logic [CB-1:0] diff_g;
    logic [CB-1:0] diff_b;
    logic          take_new;
    logic [SAT_W-1:0] best_ext;

    assign wr_in_range = ({{(RANGEW - INDEX_W){1'b0}}, entry_index}
                          < RANGEW'(PALETTE_ENTRIES));

    // Palette write and scan read
    always_ff @(posedge clk)
    begin
        if (cmd.write_en && wr_in_range)
        begin
            palette_mem[AW'(entry_index)] <= {red, green, blue};
        end
        s1_data_reg <= palette_mem[addr_reg];
    end

    // Query colour latch and scan address counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cmd.load_query)
        begin
            addr_reg <= '0;
        end
        else if (cmd.issue)
        begin
            addr_reg <= addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            q_red_reg   <= red;
            q_green_reg <= green;
            q_blue_reg  <= blue;
        end
    end

    // Absolute differences of the entry just read
    assign ent_r  = s1_data_reg[EW-1:2*CB];
    assign ent_g  = s1_data_reg[2*CB-1:CB];
    assign ent_b  = s1_data_reg[CB-1:0];
    assign diff_r = (q_red_reg >= ent_r) ? (q_red_reg - ent_r) : (ent_r - q_red_reg);
    assign diff_g = (q_green_reg >= ent_g) ? (q_green_reg - ent_g) : (ent_g - q_green_reg);
    assign diff_b = (q_blue_reg >= ent_b) ? (q_blue_reg - ent_b) : (ent_b - q_blue_reg);

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Pipeline payload: index, squares, sum
    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= addr_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_sq_r_reg <= SQW'(diff_r) * SQW'(diff_r);
        s2_sq_g_reg <= SQW'(diff_g) * SQW'(diff_g);
        s2_sq_b_reg <= SQW'(diff_b) * SQW'(diff_b);
        s3_idx_reg  <= s2_idx_reg;
        s3_sum_reg  <= DW'(s2_sq_r_reg) + DW'(s2_sq_g_reg) + DW'(s2_sq_b_reg);
    end

    // Strict less-than keeps the lowest index on a tie; entry 0 always seeds
    assign take_new = s3_valid_reg &&
                      ((s3_idx_reg == '0) || (s3_sum_reg < best_dist_reg));

    always_ff @(posedge clk)
    begin
        if (take_new)
        begin
            best_idx_reg  <= s3_idx_reg;
            best_dist_reg <= s3_sum_reg;
        end
    end

    // Output register with saturated distance
    assign best_ext = SAT_W'(best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            nearest_index_reg <= INDEX_W'(best_idx_reg);
            if (best_ext > SAT_W'(DIST_FIELD_MAX))
            begin
                nearest_distance_reg <= DIST_FIELD_MAX;
            end
            else
            begin
                nearest_distance_reg <= DIST_W'(best_dist_reg);
            end
        end
    end

    assign status.last_addr = (addr_reg == AW'(PALETTE_ENTRIES - 1));
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign status.out_busy  = out_valid_reg;

    assign out_valid        = out_valid_reg;
    assign nearest_index    = nearest_index_reg;
    assign nearest_distance = nearest_distance_reg;

endmodule

// ===== src/nearest_palette_color_top.sv =====
// Nearest palette colour search. A write transaction (operation 0) stores one
// red/green/blue entry in the palette and returns nothing; an index at or
// beyond PALETTE_ENTRIES is dropped. A query transaction (operation 1)
// scans the palette from entry 0 upward through a four-stage
// read/square/sum/compare pipeline fed by one palette memory read per cycle,
// and returns the index of the closest entry by squared distance (lowest
// index on a tie) with that distance, saturated to 16383. in_ready is low
// from the accepted query until its result is loaded into the output
// register. The palette has no reset value: write every entry before the
// first query. The result sits in an output register, so new transactions
// are taken while it waits.
`include "nearest_palette_color_top_macros.svh"

module nearest_palette_color_top
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int COMPONENT_BITS  = 6
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      operation,
    input  logic [INDEX_W-1:0]        entry_index,
    input  logic [COMPONENT_BITS-1:0] red,
    input  logic [COMPONENT_BITS-1:0] green,
    input  logic [COMPONENT_BITS-1:0] blue,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [INDEX_W-1:0]        nearest_index,
    output logic [DIST_W-1:0]         nearest_distance
);

    npc_cmd_t    cmd;
    npc_status_t status;

    npc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    npc_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .COMPONENT_BITS  (COMPONENT_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .entry_index      (entry_index),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .out_ready        (out_ready),
        .status           (status),
        .out_valid        (out_valid),
        .nearest_index    (nearest_index),
        .nearest_distance (nearest_distance)
    );

    // No new transaction while entries are still in the distance pipeline
    `NPC_ASSERT_SAME(a_no_accept_while_scanning, status.pipe_busy, !in_ready)

    // A result is never loaded over one that has not been taken
    `NPC_ASSERT_SAME(a_finish_needs_free_output, cmd.finish, !out_valid)

    // Loading a result raises out_valid in the next cycle
    `NPC_ASSERT_NEXT(a_finish_shows_result, cmd.finish, out_valid)

    // An accepted query closes the input until the scan is done
    `NPC_ASSERT_NEXT(a_query_blocks_input,
        in_valid && in_ready && (operation == OP_QUERY), !in_ready)

endmodule

// ===== tb/tb_nearest_palette_color_top.sv =====
module tb_nearest_palette_color_top;
    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;

    localparam int N_ENTRIES   = 256;
    localparam int COMP_W      = 6;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = N_ENTRIES + 16;

    // How palette colours are drawn: uniform, a coarse grid that breeds ties,
    // or a tight cluster of near neighbours
    typedef enum int {
        SPREAD_UNIFORM,
        SPREAD_COARSE,
        SPREAD_CLUSTER
    } spread_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [DIST_W-1:0]  distance;
    } colour_match_t;

    // Palette mirror and queue of nearest matches still owed by the block
    class nearest_match_scoreboard;
        logic [COMP_W-1:0] pal_r [N_ENTRIES];
        logic [COMP_W-1:0] pal_g [N_ENTRIES];
        logic [COMP_W-1:0] pal_b [N_ENTRIES];
        colour_match_t     pending [$];
        int errors;
        int writes;
        int queries;
        int results;

        task report(input string what);
            errors++;
            if (errors <= 40)
                $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        function int sq_delta(input int a, input int b);
            return (a - b) * (a - b);
        endfunction

        // A write updates the mirror; a query scans it and queues the match
        function void note_input(input logic op, input logic [INDEX_W-1:0] idx,
                                 input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                                 input logic [COMP_W-1:0] b);
            int best_dist;
            int best_idx;
            int d;
            colour_match_t m;
            if (op == OP_WRITE)
            begin
                writes++;
                if (idx < N_ENTRIES)
                begin
                    pal_r[idx] = r;
                    pal_g[idx] = g;
                    pal_b[idx] = b;
                end
                return;
            end
            queries++;
            best_dist = 32'h7FFF_FFFF;
            best_idx  = 0;
            // strict less-than: lowest index wins a tie
            for (int i = 0; i < N_ENTRIES; i++)
            begin
                d = sq_delta(r, pal_r[i]) + sq_delta(g, pal_g[i]) + sq_delta(b, pal_b[i]);
                if (d < best_dist)
                begin
                    best_dist = d;
                    best_idx  = i;
                end
            end
            if (best_dist > int'(DIST_FIELD_MAX))
                best_dist = int'(DIST_FIELD_MAX);
            m.index    = best_idx[INDEX_W-1:0];
            m.distance = best_dist[DIST_W-1:0];
            pending.push_back(m);
        endfunction

        task check_result(input logic [INDEX_W-1:0] idx, input logic [DIST_W-1:0] distance);
            colour_match_t want;
            results++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result: index %0d distance %0d", idx, distance));
                return;
            end
            want = pending.pop_front();
            if (idx !== want.index)
                report($sformatf("nearest_index %0d, wanted %0d", idx, want.index));
            if (distance !== want.distance)
                report($sformatf("nearest_distance %0d, wanted %0d", distance,
                                 want.distance));
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      operation;
    logic [INDEX_W-1:0]        entry_index;
    logic [COMP_W-1:0]         red;
    logic [COMP_W-1:0]         green;
    logic [COMP_W-1:0]         blue;
    logic                      out_valid;
    logic                      out_ready;
    logic [INDEX_W-1:0]        nearest_index;
    logic [DIST_W-1:0]         nearest_distance;

    nearest_match_scoreboard sb = new();
    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;
    int holds_done = 0;

    nearest_palette_color_top #(
        .PALETTE_ENTRIES (N_ENTRIES),
        .COMPONENT_BITS  (COMP_W)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .entry_index      (entry_index),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .nearest_index    (nearest_index),
        .nearest_distance (nearest_distance)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one transaction, with an occasional gap first; returns on acceptance
    task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                             input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                             input logic [COMP_W-1:0] b);
        if (!no_idle && $urandom_range(0, 99) < 10)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        operation   <= op;
        entry_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(op, idx, r, g, b);
    endtask

    function automatic logic [COMP_W-1:0] pick_comp(input spread_t s);
        case (s)
            SPREAD_COARSE:  return COMP_W'(21 * $urandom_range(0, 3));
            SPREAD_CLUSTER: return COMP_W'(28 + $urandom_range(0, 7));
            default:        return COMP_W'($urandom_range(0, 63));
        endcase
    endfunction

    // Query colour: near an existing entry, at the corners, or anywhere
    task automatic send_query();
        int roll;
        int k;
        logic [COMP_W-1:0] qr;
        logic [COMP_W-1:0] qg;
        logic [COMP_W-1:0] qb;
        roll = $urandom_range(0, 99);
        if (roll < 40)
        begin
            k  = $urandom_range(0, N_ENTRIES - 1);
            qr = sb.pal_r[k] ^ COMP_W'($urandom_range(0, 3));
            qg = sb.pal_g[k] ^ COMP_W'($urandom_range(0, 3));
            qb = sb.pal_b[k] ^ COMP_W'($urandom_range(0, 3));
        end
        else if (roll < 60)
        begin
            qr = $urandom_range(0, 1) ? 6'd63 : 6'd0;
            qg = $urandom_range(0, 1) ? 6'd63 : 6'd0;
            qb = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        end
        else
        begin
            qr = COMP_W'($urandom_range(0, 63));
            qg = COMP_W'($urandom_range(0, 63));
            qb = COMP_W'($urandom_range(0, 63));
        end
        send_item(OP_QUERY, INDEX_W'($urandom_range(0, 255)), qr, qg, qb);
    endtask

    // Stop offering and wait for every owed result
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Result sink: random back-pressure, plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 10);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(nearest_index, nearest_distance);
    end

    // Stimulus
    initial
    begin
        spread_t spread;
        in_valid    = 1'b0;
        operation   = OP_WRITE;
        entry_index = '0;
        red         = '0;
        green       = '0;
        blue        = '0;
        rst_n       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Whole palette black before any query
        for (int i = 0; i < N_ENTRIES; i++)
            send_item(OP_WRITE, INDEX_W'(i), 6'd0, 6'd0, 6'd0);

        // Directed: farthest colour, all-way tie, corner entries, near ties
        send_query_fixed: begin
            send_item(OP_QUERY, 8'd0,   6'd63, 6'd63, 6'd63);
            send_item(OP_QUERY, 8'd255, 6'd0,  6'd0,  6'd0);
            send_item(OP_WRITE, 8'd255, 6'd63, 6'd63, 6'd63);
            send_item(OP_QUERY, 8'd0,   6'd63, 6'd63, 6'd63);
            send_item(OP_WRITE, 8'd128, 6'd63, 6'd63, 6'd63);
            send_item(OP_QUERY, 8'd17,  6'd60, 6'd62, 6'd63);
            send_item(OP_WRITE, 8'd7,   6'd32, 6'd16, 6'd48);
            send_item(OP_QUERY, 8'd7,   6'd32, 6'd16, 6'd48);
            send_item(OP_QUERY, 8'd170, 6'd33, 6'd17, 6'd49);
            send_item(OP_WRITE, 8'd0,   6'd63, 6'd0,  6'd0);
            send_item(OP_QUERY, 8'd85,  6'd63, 6'd0,  6'd0);
            send_item(OP_QUERY, 8'd0,   6'd0,  6'd63, 6'd0);
            send_item(OP_WRITE, 8'd10,  6'd10, 6'd10, 6'd10);
            send_item(OP_WRITE, 8'd20,  6'd12, 6'd10, 6'd10);
            send_item(OP_QUERY, 8'd3,   6'd11, 6'd10, 6'd10);
            send_item(OP_QUERY, 8'd0,   6'd0,  6'd0,  6'd63);
        end
        wait_drained();

        // Random palette, then a mix of writes and queries
        spread = spread_t'($urandom_range(0, 2));
        for (int i = 0; i < N_ENTRIES; i++)
            send_item(OP_WRITE, INDEX_W'(i), pick_comp(spread), pick_comp(spread),
                      pick_comp(spread));
        for (int n = 0; n < 500; n++)
        begin
            if (n % 100 == 0)
                spread = spread_t'($urandom_range(0, 2));
            no_idle = (n >= 150 && n < 250);
            if (n == 300)
            begin
                // sink stalls while queries keep coming, so the block backs up
                hold_req = 1'b1;
                repeat (10) send_query();
            end
            if (n == 400)
                wait_drained();
            if ($urandom_range(0, 99) < 35)
                send_query();
            else
                send_item(OP_WRITE, INDEX_W'($urandom_range(0, 255)), pick_comp(spread),
                          pick_comp(spread), pick_comp(spread));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d palette writes and %0d colour queries; %0d results checked.",
                 sb.writes, sb.queries, sb.results);
        $display("Included a full-palette tie, the largest distance and %0d long sink stall(s).",
                 holds_done);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #15_000_000;
        $display("Timeout with %0d results outstanding", sb.pending.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== nearest_palette_color_top.f =====
+incdir+src
src/npc_pkg.sv
src/npc_ctrl.sv
src/npc_datapath.sv
src/nearest_palette_color_top.sv
tb/tb_nearest_palette_color_top.sv
